### sv/cpo_pkg.sv
// Shared types, widths and codes for the convex polygon overlap test block.
package cpo_pkg;

    localparam int MAX_VERTICES_DEF   = 64;
    localparam int MAX_ITERATIONS_DEF = 32;
    localparam int COORD_BITS_DEF     = 12;

    // Arithmetic widths, sized for the widest coordinates.
    localparam int CW  = 12;        // vertex coordinate
    localparam int PW  = CW + 1;    // Minkowski difference point
    localparam int EW  = CW + 2;    // edge and origin vectors
    localparam int ZW  = 2 * EW + 1; // cross product
    localparam int DW  = ZW + EW + 2; // search direction and scaled normals
    localparam int VW  = CW + DW;   // vertex times direction
    localparam int VSW = VW + 1;    // vertex dot product
    localparam int MW  = DW + EW;   // normal times point
    localparam int SW  = MW + 1;    // normal dot product

    typedef enum logic [1:0] {
        OP_CLEAR    = 2'd0,
        OP_APPEND_A = 2'd1,
        OP_APPEND_B = 2'd2,
        OP_RUN      = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        RES_DECIDED = 2'd0,
        RES_CAP     = 2'd1,
        RES_EMPTY   = 2'd2,
        RES_DROPPED = 2'd3
    } res_status_t;

    typedef struct packed {
        op_t                   operation;
        logic signed [CW-1:0]  coord_x;
        logic signed [CW-1:0]  coord_y;
    } request_t;

    typedef struct packed {
        logic        collided;
        res_status_t status;
    } result_t;

    typedef enum logic [1:0] {
        LD_LINE = 2'd0,
        LD_N    = 2'd1,
        LD_T1   = 2'd2,
        LD_T2   = 2'd3
    } ld_sel_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_SCAN_INIT,
        S_SCAN,
        S_FIRST,
        S_LOOP,
        S_CHK_MUL,
        S_CHK_TEST,
        S_LOAD_RED,
        S_Z_MUL,
        S_Z_SUB,
        S_D_DIR,
        S_S1_D,
        S_S1_MUL,
        S_S1_TEST,
        S_S2_D,
        S_S2_MUL,
        S_S2_TEST
    } state_t;

    typedef struct packed {
        logic    clear;
        logic    app_a;
        logic    app_b;
        logic    dir_init;
        logic    scan_clr;
        logic    scan_run;
        logic    sp_load;
        logic    first_load;
        logic    insert;
        logic    ld_en;
        ld_sel_t ld_sel;
        logic    z_mul;
        logic    z_sub;
        logic    d_en;
        logic    d_q_w;
        logic    d_to_dir;
        logic    s_mul;
        logic    s_chk;
        logic    red_t1;
        logic    red_t2;
    } dp_cmd_t;

    typedef struct packed {
        logic       empty;
        logic       overflow;
        logic       scan_done;
        logic       s_neg;
        logic       s_pos;
        logic [1:0] size;
    } dp_stat_t;

endpackage

### sv/cpo_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module cpo_ram #(
    parameter int WIDTH  = 24,
    parameter int DEPTH  = 64,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### sv/cpo_dp.sv
// Datapath: vertex stores, support scan, simplex registers and GJK arithmetic.
module cpo_dp #(
    parameter int MAX_VERTICES = cpo_pkg::MAX_VERTICES_DEF,
    parameter int COORD_BITS   = cpo_pkg::COORD_BITS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  cpo_pkg::request_t request,
    input  cpo_pkg::dp_cmd_t  cmd,
    output cpo_pkg::dp_stat_t stat
);

    localparam int AW   = $clog2(MAX_VERTICES);
    localparam int CNTW = $clog2(MAX_VERTICES + 1);
    localparam int RW   = 2 * COORD_BITS;
    localparam int CW   = cpo_pkg::CW;
    localparam int PW   = cpo_pkg::PW;
    localparam int EW   = cpo_pkg::EW;
    localparam int ZW   = cpo_pkg::ZW;
    localparam int DW   = cpo_pkg::DW;
    localparam int VW   = cpo_pkg::VW;
    localparam int VSW  = cpo_pkg::VSW;
    localparam int MW   = cpo_pkg::MW;
    localparam int SW   = cpo_pkg::SW;

    // ---------------- vertex stores ----------------
    logic [CNTW-1:0] cnt_a_reg, cnt_b_reg;
    logic            ovf_reg;
    logic            we_a, we_b;
    logic [RW-1:0]   wdata, rd_a, rd_b;
    logic [CNTW-1:0] idx_reg, max_cnt;
    logic            issue;

    assign wdata = {request.coord_y[COORD_BITS-1:0], request.coord_x[COORD_BITS-1:0]};
    assign we_a  = cmd.app_a && (cnt_a_reg < CNTW'(MAX_VERTICES));
    assign we_b  = cmd.app_b && (cnt_b_reg < CNTW'(MAX_VERTICES));

    cpo_ram #(.WIDTH(RW), .DEPTH(MAX_VERTICES)) u_ram_a (
        .clk(clk), .we(we_a), .waddr(cnt_a_reg[AW-1:0]), .wdata(wdata),
        .raddr(idx_reg[AW-1:0]), .rdata(rd_a)
    );

    cpo_ram #(.WIDTH(RW), .DEPTH(MAX_VERTICES)) u_ram_b (
        .clk(clk), .we(we_b), .waddr(cnt_b_reg[AW-1:0]), .wdata(wdata),
        .raddr(idx_reg[AW-1:0]), .rdata(rd_b)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_a_reg <= '0;
            cnt_b_reg <= '0;
            ovf_reg   <= 1'b0;
        end
        else if (cmd.clear)
        begin
            cnt_a_reg <= '0;
            cnt_b_reg <= '0;
            ovf_reg   <= 1'b0;
        end
        else
        begin
            if (we_a)
            begin
                cnt_a_reg <= cnt_a_reg + 1'b1;
            end
            if (we_b)
            begin
                cnt_b_reg <= cnt_b_reg + 1'b1;
            end
            if ((cmd.app_a && !we_a) || (cmd.app_b && !we_b))
            begin
                ovf_reg <= 1'b1;
            end
        end
    end

    // ---------------- support scan ----------------
    logic signed [CW-1:0]  ax, ay, bx, by;
    logic signed [DW-1:0]  dir_x_reg, dir_y_reg;
    logic                  v1a_reg, v1b_reg, v2a_reg, v2b_reg;
    logic signed [CW-1:0]  ax2_reg, ay2_reg, bx2_reg, by2_reg;
    logic signed [VW-1:0]  pax_reg, pay_reg, pbx_reg, pby_reg;
    logic signed [VSW-1:0] dot_a, dot_b, best_dot_a_reg, best_dot_b_reg;
    logic                  bva_reg, bvb_reg;
    logic signed [CW-1:0]  best_ax_reg, best_ay_reg, best_bx_reg, best_by_reg;

    assign ax = CW'($signed(rd_a[COORD_BITS-1:0]));
    assign ay = CW'($signed(rd_a[RW-1:COORD_BITS]));
    assign bx = CW'($signed(rd_b[COORD_BITS-1:0]));
    assign by = CW'($signed(rd_b[RW-1:COORD_BITS]));

    assign max_cnt = (cnt_a_reg > cnt_b_reg) ? cnt_a_reg : cnt_b_reg;
    assign issue   = cmd.scan_run && (idx_reg < max_cnt);
    assign dot_a   = pax_reg + pay_reg;
    assign dot_b   = pbx_reg + pby_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg <= '0;
            v1a_reg <= 1'b0;
            v1b_reg <= 1'b0;
            v2a_reg <= 1'b0;
            v2b_reg <= 1'b0;
            bva_reg <= 1'b0;
            bvb_reg <= 1'b0;
        end
        else if (cmd.scan_clr)
        begin
            idx_reg <= '0;
            v1a_reg <= 1'b0;
            v1b_reg <= 1'b0;
            v2a_reg <= 1'b0;
            v2b_reg <= 1'b0;
            bva_reg <= 1'b0;
            bvb_reg <= 1'b0;
        end
        else
        begin
            if (issue)
            begin
                idx_reg <= idx_reg + 1'b1;
            end
            v1a_reg <= issue && (idx_reg < cnt_a_reg);
            v1b_reg <= issue && (idx_reg < cnt_b_reg);
            v2a_reg <= v1a_reg;
            v2b_reg <= v1b_reg;
            if (v2a_reg && (!bva_reg || dot_a > best_dot_a_reg))
            begin
                bva_reg <= 1'b1;
            end
            if (v2b_reg && (!bvb_reg || dot_b < best_dot_b_reg))
            begin
                bvb_reg <= 1'b1;
            end
        end
    end

    // B is scanned against the negated direction: keep the strict minimum.
    always_ff @(posedge clk)
    begin
        ax2_reg <= ax;
        ay2_reg <= ay;
        bx2_reg <= bx;
        by2_reg <= by;
        pax_reg <= ax * dir_x_reg;
        pay_reg <= ay * dir_y_reg;
        pbx_reg <= bx * dir_x_reg;
        pby_reg <= by * dir_y_reg;
        if (v2a_reg && (!bva_reg || dot_a > best_dot_a_reg))
        begin
            best_dot_a_reg <= dot_a;
            best_ax_reg    <= ax2_reg;
            best_ay_reg    <= ay2_reg;
        end
        if (v2b_reg && (!bvb_reg || dot_b < best_dot_b_reg))
        begin
            best_dot_b_reg <= dot_b;
            best_bx_reg    <= bx2_reg;
            best_by_reg    <= by2_reg;
        end
    end

    // ---------------- simplex and GJK arithmetic ----------------
    logic signed [PW-1:0] sp_x_reg, sp_y_reg;
    logic signed [PW-1:0] p_x_reg [3];
    logic signed [PW-1:0] p_y_reg [3];
    logic [1:0]           size_reg;
    logic signed [EW-1:0] e_x_reg, e_y_reg, w_x_reg, w_y_reg;
    logic signed [EW-1:0] t1_x, t1_y, t2_x, t2_y, m_x, m_y, l_x, l_y, nl_x, nl_y;
    logic signed [EW-1:0] e_x_next, e_y_next, w_x_next, w_y_next, q_x, q_y;
    logic signed [2*EW-1:0] zp1_reg, zp2_reg;
    logic signed [ZW-1:0] z_reg;
    logic signed [DW-1:0] u_reg, v_reg, d_x, d_y, o1_x, o1_y;
    logic signed [EW-1:0] o2_x, o2_y;
    logic signed [MW-1:0] sp1_reg, sp2_reg;
    logic signed [SW-1:0] s_sum;

    assign t1_x = EW'(p_x_reg[0]) - EW'(p_x_reg[2]);
    assign t1_y = EW'(p_y_reg[0]) - EW'(p_y_reg[2]);
    assign t2_x = EW'(p_x_reg[1]) - EW'(p_x_reg[2]);
    assign t2_y = EW'(p_y_reg[1]) - EW'(p_y_reg[2]);
    assign m_x  = -(EW'(p_x_reg[2]));
    assign m_y  = -(EW'(p_y_reg[2]));
    assign l_x  = EW'(p_x_reg[0]) - EW'(p_x_reg[1]);
    assign l_y  = EW'(p_y_reg[0]) - EW'(p_y_reg[1]);
    assign nl_x = -(EW'(p_x_reg[1]));
    assign nl_y = -(EW'(p_y_reg[1]));

    always_comb
    begin
        unique case (cmd.ld_sel)
            cpo_pkg::LD_LINE:
            begin
                e_x_next = l_x;  e_y_next = l_y;  w_x_next = nl_x; w_y_next = nl_y;
            end
            cpo_pkg::LD_N:
            begin
                e_x_next = t2_x; e_y_next = t2_y; w_x_next = t1_x; w_y_next = t1_y;
            end
            cpo_pkg::LD_T1:
            begin
                e_x_next = t1_x; e_y_next = t1_y; w_x_next = m_x;  w_y_next = m_y;
            end
            default:
            begin
                e_x_next = t2_x; e_y_next = t2_y; w_x_next = m_x;  w_y_next = m_y;
            end
        endcase
    end

    // Perpendicular scaled by the cross product: (-z*qy, z*qx).
    assign q_x = cmd.d_q_w ? w_x_reg : e_x_reg;
    assign q_y = cmd.d_q_w ? w_y_reg : e_y_reg;
    assign d_x = -(z_reg * q_y);
    assign d_y = z_reg * q_x;

    assign o1_x  = cmd.s_chk ? dir_x_reg : u_reg;
    assign o1_y  = cmd.s_chk ? dir_y_reg : v_reg;
    assign o2_x  = cmd.s_chk ? EW'(sp_x_reg) : m_x;
    assign o2_y  = cmd.s_chk ? EW'(sp_y_reg) : m_y;
    assign s_sum = sp1_reg + sp2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_reg <= '0;
        end
        else if (cmd.first_load)
        begin
            size_reg <= 2'd1;
        end
        else if (cmd.insert && size_reg != 2'd3)
        begin
            size_reg <= size_reg + 2'd1;
        end
        else if (cmd.red_t1 || cmd.red_t2)
        begin
            size_reg <= 2'd2;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.sp_load)
        begin
            sp_x_reg <= best_ax_reg - best_bx_reg;
            sp_y_reg <= best_ay_reg - best_by_reg;
        end
        if (cmd.first_load)
        begin
            p_x_reg[0] <= sp_x_reg;
            p_y_reg[0] <= sp_y_reg;
        end
        if (cmd.insert && size_reg != 2'd3)
        begin
            p_x_reg[size_reg] <= sp_x_reg;
            p_y_reg[size_reg] <= sp_y_reg;
        end
        if (cmd.red_t1)
        begin
            p_x_reg[1] <= p_x_reg[2];
            p_y_reg[1] <= p_y_reg[2];
        end
        if (cmd.red_t2)
        begin
            p_x_reg[0] <= p_x_reg[2];
            p_y_reg[0] <= p_y_reg[2];
        end
        if (cmd.dir_init)
        begin
            dir_x_reg <= DW'(1);
            dir_y_reg <= '0;
        end
        else if (cmd.first_load)
        begin
            dir_x_reg <= -(DW'(sp_x_reg));
            dir_y_reg <= -(DW'(sp_y_reg));
        end
        else if (cmd.d_en && cmd.d_to_dir)
        begin
            dir_x_reg <= d_x;
            dir_y_reg <= d_y;
        end
        if (cmd.d_en && !cmd.d_to_dir)
        begin
            u_reg <= d_x;
            v_reg <= d_y;
        end
        if (cmd.ld_en)
        begin
            e_x_reg <= e_x_next;
            e_y_reg <= e_y_next;
            w_x_reg <= w_x_next;
            w_y_reg <= w_y_next;
        end
        if (cmd.z_mul)
        begin
            zp1_reg <= e_x_reg * w_y_reg;
            zp2_reg <= e_y_reg * w_x_reg;
        end
        if (cmd.z_sub)
        begin
            z_reg <= ZW'(zp1_reg) - ZW'(zp2_reg);
        end
        if (cmd.s_mul)
        begin
            sp1_reg <= o1_x * o2_x;
            sp2_reg <= o1_y * o2_y;
        end
    end

    assign stat.empty     = (cnt_a_reg == '0) || (cnt_b_reg == '0);
    assign stat.overflow  = ovf_reg;
    assign stat.scan_done = (idx_reg >= max_cnt) && !v1a_reg && !v1b_reg
                            && !v2a_reg && !v2b_reg;
    assign stat.s_neg     = s_sum[SW-1];
    assign stat.s_pos     = !s_sum[SW-1] && (s_sum != '0);
    assign stat.size      = size_reg;

endmodule

### sv/cpo_ctrl.sv
// Controller: sequences commands, scans, GJK steps and the iteration cap.
module cpo_ctrl #(
    parameter int MAX_ITERATIONS = cpo_pkg::MAX_ITERATIONS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  cpo_pkg::op_t      operation,
    input  cpo_pkg::dp_stat_t stat,
    output cpo_pkg::dp_cmd_t  cmd,
    output logic              busy,
    output logic              done,
    output cpo_pkg::result_t  result
);

    localparam int ITW = $clog2(MAX_ITERATIONS + 1);

    cpo_pkg::state_t  state_reg, state_next;
    logic [ITW-1:0]   iter_reg, iter_next;
    logic             first_reg, first_next;
    logic             tri_reg, tri_next;
    logic             done_reg, done_next;
    cpo_pkg::result_t result_reg, result_next;
    cpo_pkg::res_status_t decided;

    assign decided = stat.overflow ? cpo_pkg::RES_DROPPED : cpo_pkg::RES_DECIDED;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            cpo_pkg::S_IDLE:
            begin
                if (start && operation == cpo_pkg::OP_RUN && !stat.empty)
                begin
                    state_next = cpo_pkg::S_SCAN_INIT;
                end
            end
            cpo_pkg::S_SCAN_INIT: state_next = cpo_pkg::S_SCAN;
            cpo_pkg::S_SCAN:
            begin
                if (stat.scan_done)
                begin
                    state_next = first_reg ? cpo_pkg::S_FIRST : cpo_pkg::S_CHK_MUL;
                end
            end
            cpo_pkg::S_FIRST: state_next = cpo_pkg::S_LOOP;
            cpo_pkg::S_LOOP:
            begin
                state_next = (iter_reg == ITW'(MAX_ITERATIONS)) ? cpo_pkg::S_IDLE
                                                               : cpo_pkg::S_SCAN_INIT;
            end
            cpo_pkg::S_CHK_MUL: state_next = cpo_pkg::S_CHK_TEST;
            cpo_pkg::S_CHK_TEST:
            begin
                state_next = stat.s_neg ? cpo_pkg::S_IDLE : cpo_pkg::S_LOAD_RED;
            end
            cpo_pkg::S_LOAD_RED: state_next = cpo_pkg::S_Z_MUL;
            cpo_pkg::S_Z_MUL:    state_next = cpo_pkg::S_Z_SUB;
            cpo_pkg::S_Z_SUB:    state_next = tri_reg ? cpo_pkg::S_D_DIR : cpo_pkg::S_S1_D;
            cpo_pkg::S_D_DIR:    state_next = cpo_pkg::S_LOOP;
            cpo_pkg::S_S1_D:     state_next = cpo_pkg::S_S1_MUL;
            cpo_pkg::S_S1_MUL:   state_next = cpo_pkg::S_S1_TEST;
            cpo_pkg::S_S1_TEST:
            begin
                state_next = stat.s_pos ? cpo_pkg::S_Z_MUL : cpo_pkg::S_S2_D;
            end
            cpo_pkg::S_S2_D:     state_next = cpo_pkg::S_S2_MUL;
            cpo_pkg::S_S2_MUL:   state_next = cpo_pkg::S_S2_TEST;
            cpo_pkg::S_S2_TEST:
            begin
                state_next = stat.s_neg ? cpo_pkg::S_Z_MUL : cpo_pkg::S_IDLE;
            end
            default: state_next = cpo_pkg::S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd         = '0;
        done_next   = 1'b0;
        result_next = result_reg;
        iter_next   = iter_reg;
        first_next  = first_reg;
        tri_next    = tri_reg;
        unique case (state_reg)
            cpo_pkg::S_IDLE:
            begin
                if (start)
                begin
                    unique case (operation)
                        cpo_pkg::OP_CLEAR:    cmd.clear = 1'b1;
                        cpo_pkg::OP_APPEND_A: cmd.app_a = 1'b1;
                        cpo_pkg::OP_APPEND_B: cmd.app_b = 1'b1;
                        default:
                        begin
                            if (stat.empty)
                            begin
                                done_next          = 1'b1;
                                result_next.collided = 1'b0;
                                result_next.status   = cpo_pkg::RES_EMPTY;
                            end
                            else
                            begin
                                cmd.dir_init = 1'b1;
                                first_next   = 1'b1;
                            end
                        end
                    endcase
                end
            end
            cpo_pkg::S_SCAN_INIT: cmd.scan_clr = 1'b1;
            cpo_pkg::S_SCAN:
            begin
                cmd.scan_run = 1'b1;
                cmd.sp_load  = stat.scan_done;
            end
            cpo_pkg::S_FIRST:
            begin
                cmd.first_load = 1'b1;
                first_next     = 1'b0;
                iter_next      = '0;
            end
            cpo_pkg::S_LOOP:
            begin
                if (iter_reg == ITW'(MAX_ITERATIONS))
                begin
                    done_next            = 1'b1;
                    result_next.collided = 1'b0;
                    result_next.status   = cpo_pkg::RES_CAP;
                end
                else
                begin
                    iter_next = iter_reg + 1'b1;
                end
            end
            cpo_pkg::S_CHK_MUL:
            begin
                cmd.s_mul = 1'b1;
                cmd.s_chk = 1'b1;
            end
            cpo_pkg::S_CHK_TEST:
            begin
                if (stat.s_neg)
                begin
                    done_next            = 1'b1;
                    result_next.collided = 1'b0;
                    result_next.status   = decided;
                end
                else
                begin
                    cmd.insert = 1'b1;
                end
            end
            cpo_pkg::S_LOAD_RED:
            begin
                cmd.ld_en  = 1'b1;
                cmd.ld_sel = (stat.size == 2'd2) ? cpo_pkg::LD_LINE : cpo_pkg::LD_N;
                tri_next   = (stat.size == 2'd2);
            end
            cpo_pkg::S_Z_MUL: cmd.z_mul = 1'b1;
            cpo_pkg::S_Z_SUB: cmd.z_sub = 1'b1;
            cpo_pkg::S_D_DIR:
            begin
                cmd.d_en     = 1'b1;
                cmd.d_to_dir = 1'b1;
            end
            cpo_pkg::S_S1_D:
            begin
                cmd.d_en  = 1'b1;
                cmd.d_q_w = 1'b1;
            end
            cpo_pkg::S_S1_MUL: cmd.s_mul = 1'b1;
            cpo_pkg::S_S1_TEST:
            begin
                if (stat.s_pos)
                begin
                    cmd.ld_en  = 1'b1;
                    cmd.ld_sel = cpo_pkg::LD_T1;
                    cmd.red_t1 = 1'b1;
                    tri_next   = 1'b1;
                end
            end
            cpo_pkg::S_S2_D:   cmd.d_en  = 1'b1;
            cpo_pkg::S_S2_MUL: cmd.s_mul = 1'b1;
            cpo_pkg::S_S2_TEST:
            begin
                // Second normal is the negated form, so its test flips sign.
                if (stat.s_neg)
                begin
                    cmd.ld_en  = 1'b1;
                    cmd.ld_sel = cpo_pkg::LD_T2;
                    cmd.red_t2 = 1'b1;
                    tri_next   = 1'b1;
                end
                else
                begin
                    done_next            = 1'b1;
                    result_next.collided = 1'b1;
                    result_next.status   = decided;
                end
            end
            default: cmd = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= cpo_pkg::S_IDLE;
            iter_reg  <= '0;
            first_reg <= 1'b0;
            tri_reg   <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            iter_reg  <= iter_next;
            first_reg <= first_next;
            tri_reg   <= tri_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign busy   = (state_reg != cpo_pkg::S_IDLE);
    assign done   = done_reg;
    assign result = result_reg;

endmodule

### sv/convex_polygon_overlap_test_top.sv
// Top level of the convex polygon overlap test (2D GJK on A - B).
//
// Channel   Handshake          Payload            Direction
// request   start / busy       request_t          in
// result    done (one cycle)   result_t           out
//
// Clear and append transactions produce no result.
// A run transaction takes, per GJK iteration, one scan of both vertex stores
// (every index below the larger vertex count, read from both stores through one
// shared read address) plus sequenced steps (loop check, support check, cross
// product, both triangle normals and the new direction); at most
// MAX_ITERATIONS iterations follow one initial scan.
// The result strobe done is registered from the decision; busy is low by then.
// Reset (rst_n low, asynchronous) empties both shapes and clears the drop flag.
// The receiver cannot stall: each result is present for exactly one cycle.
module convex_polygon_overlap_test_top #(
    parameter int MAX_VERTICES   = cpo_pkg::MAX_VERTICES_DEF,
    parameter int MAX_ITERATIONS = cpo_pkg::MAX_ITERATIONS_DEF,
    parameter int COORD_BITS     = cpo_pkg::COORD_BITS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  cpo_pkg::request_t request,
    output logic              done,
    output cpo_pkg::result_t  result
);

    cpo_pkg::dp_cmd_t  cmd;
    cpo_pkg::dp_stat_t stat;

    // Sequencer: owns the iteration count and the result register.
    cpo_ctrl #(.MAX_ITERATIONS(MAX_ITERATIONS)) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .operation (request.operation),
        .stat      (stat),
        .cmd       (cmd),
        .busy      (busy),
        .done      (done),
        .result    (result)
    );

    // Vertex stores, support scan and simplex math.
    cpo_dp #(.MAX_VERTICES(MAX_VERTICES), .COORD_BITS(COORD_BITS)) u_dp (
        .clk     (clk),
        .rst_n   (rst_n),
        .request (request),
        .cmd     (cmd),
        .stat    (stat)
    );

    // A result only appears once the sequencer is back at rest.
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result strobe while busy");

    // Scans only run on two non-empty shapes.
    a_scan_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.scan_run |-> !stat.empty)
        else $error("scan with an empty shape");

    // Triangle normals are only evaluated on a full simplex.
    a_tri_size: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.s_mul && !cmd.s_chk) |-> stat.size == 2'd3)
        else $error("triangle test without three points");

    // A result strobe only rises in the cycle after the sequencer was busy or saw a start.
    a_done_follow: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(done) |-> ($past(busy) || $past(start)))
        else $error("result strobe without a run");

endmodule

### tb/cpo_checker.sv
// Result checker for the convex polygon overlap test: tracks both shapes, predicts each run.
`timescale 1ns / 1ps
module cpo_checker #(
    parameter int MAX_VERTICES   = cpo_pkg::MAX_VERTICES_DEF,
    parameter int MAX_ITERATIONS = cpo_pkg::MAX_ITERATIONS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic              busy,
    input  cpo_pkg::request_t request,
    input  logic              done,
    input  cpo_pkg::result_t  result,
    output int                fail_count,
    output int                pending
);
    typedef struct {
        longint x;
        longint y;
    } vec2_t;

    vec2_t            poly_a [MAX_VERTICES];
    vec2_t            poly_b [MAX_VERTICES];
    int               count_a;
    int               count_b;
    bit               dropped;
    cpo_pkg::result_t verdict_q [$];

    // support point of one polygon along (dx, dy); first maximum wins
    function automatic vec2_t extreme_point(input bit use_b, input int n,
                                            input longint dx, input longint dy);
        vec2_t  best;
        vec2_t  p;
        longint best_dot;
        longint d;
        best = use_b ? poly_b[0] : poly_a[0];
        best_dot = best.x * dx + best.y * dy;
        for (int i = 1; i < n; i++)
        begin
            p = use_b ? poly_b[i] : poly_a[i];
            d = p.x * dx + p.y * dy;
            if (d > best_dot)
            begin
                best_dot = d;
                best = p;
            end
        end
        return best;
    endfunction

    function automatic vec2_t minkowski_point(input longint dx, input longint dy);
        vec2_t a;
        vec2_t b;
        vec2_t r;
        a = extreme_point(1'b0, count_a, dx, dy);
        b = extreme_point(1'b1, count_b, -dx, -dy);
        r.x = a.x - b.x;
        r.y = a.y - b.y;
        return r;
    endfunction

    // perpendicular of edge e on the side of w
    function automatic vec2_t edge_normal(input longint ex, input longint ey,
                                          input longint wx, input longint wy);
        longint z;
        vec2_t  r;
        z = ex * wy - ey * wx;
        r.x = -z * ey;
        r.y = z * ex;
        return r;
    endfunction

    function automatic cpo_pkg::result_t overlap_verdict();
        vec2_t            s [3];
        vec2_t            dir;
        vec2_t            sp;
        vec2_t            a;
        int               size;
        int               decided;
        longint           t1x, t1y, t2x, t2y, n, mx, my;
        cpo_pkg::result_t r;
        if (count_a == 0 || count_b == 0)
        begin
            r.collided = 1'b0;
            r.status = cpo_pkg::RES_EMPTY;
            return r;
        end
        s[0] = minkowski_point(1, 0);
        size = 1;
        dir.x = -s[0].x;
        dir.y = -s[0].y;
        decided = -1;
        for (int it = 0; it < MAX_ITERATIONS && decided < 0; it++)
        begin
            sp = minkowski_point(dir.x, dir.y);
            if (sp.x * dir.x + sp.y * dir.y < 0)
            begin
                decided = 0;
            end
            else
            begin
                if (size < 3)
                begin
                    s[size] = sp;
                    size++;
                end
                if (size == 2)
                begin
                    dir = edge_normal(s[0].x - s[1].x, s[0].y - s[1].y, -s[1].x, -s[1].y);
                end
                else if (size == 3)
                begin
                    a = s[2];
                    t1x = s[0].x - a.x;
                    t1y = s[0].y - a.y;
                    t2x = s[1].x - a.x;
                    t2y = s[1].y - a.y;
                    n = t2x * t1y - t2y * t1x;
                    mx = -a.x;
                    my = -a.y;
                    if ((-n * t1y) * mx + (n * t1x) * my > 0)
                    begin
                        size = 2;
                        s[1] = a;
                        dir = edge_normal(t1x, t1y, mx, my);
                    end
                    else if ((t2y * n) * mx + (-t2x * n) * my > 0)
                    begin
                        size = 2;
                        s[0] = a;
                        dir = edge_normal(t2x, t2y, mx, my);
                    end
                    else
                    begin
                        decided = 1;
                    end
                end
            end
        end
        if (decided < 0)
        begin
            r.collided = 1'b0;
            r.status = cpo_pkg::RES_CAP;
        end
        else
        begin
            r.collided = decided[0];
            r.status = dropped ? cpo_pkg::RES_DROPPED : cpo_pkg::RES_DECIDED;
        end
        return r;
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        cpo_pkg::result_t expd;
        vec2_t            v;
        int               errs;
        if (!rst_n)
        begin
            count_a <= 0;
            count_b <= 0;
            dropped <= 1'b0;
            fail_count <= 0;
            pending <= 0;
            verdict_q.delete();
        end
        else
        begin
            errs = 0;
            // check before the new transaction updates the model
            if (done)
            begin
                if (verdict_q.size() == 0)
                begin
                    $error("result with nothing pending: collided=%0d status=%0d",
                           result.collided, result.status);
                    errs++;
                end
                else
                begin
                    expd = verdict_q.pop_front();
                    if (result.collided !== expd.collided)
                    begin
                        $error("collided: expected %0d actual %0d",
                               expd.collided, result.collided);
                        errs++;
                    end
                    if (result.status !== expd.status)
                    begin
                        $error("status: expected %0d actual %0d", expd.status, result.status);
                        errs++;
                    end
                end
            end
            fail_count <= fail_count + errs;
            if (start && !busy)
            begin
                v.x = longint'(request.coord_x);
                v.y = longint'(request.coord_y);
                case (request.operation)
                    cpo_pkg::OP_CLEAR:
                    begin
                        count_a <= 0;
                        count_b <= 0;
                        dropped <= 1'b0;
                    end
                    cpo_pkg::OP_APPEND_A:
                    begin
                        if (count_a < MAX_VERTICES)
                        begin
                            poly_a[count_a] <= v;
                            count_a <= count_a + 1;
                        end
                        else
                            dropped <= 1'b1;
                    end
                    cpo_pkg::OP_APPEND_B:
                    begin
                        if (count_b < MAX_VERTICES)
                        begin
                            poly_b[count_b] <= v;
                            count_b <= count_b + 1;
                        end
                        else
                            dropped <= 1'b1;
                    end
                    default:
                        verdict_q.push_back(overlap_verdict());
                endcase
            end
            pending <= verdict_q.size();
        end
    end
endmodule

### tb/tb.sv
// Stimulus and verdict for the convex polygon overlap test block.
`timescale 1ns / 1ps
module tb;

    logic              clk;
    logic              rst_n;
    logic              start;
    logic              busy;
    cpo_pkg::request_t request;
    logic              done;
    cpo_pkg::result_t  result;
    int                fail_count;
    int                pending;
    int                idle_pct;

    convex_polygon_overlap_test_top dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .request (request),
        .done    (done),
        .result  (result)
    );

    cpo_checker #(
        .MAX_VERTICES   (cpo_pkg::MAX_VERTICES_DEF),
        .MAX_ITERATIONS (cpo_pkg::MAX_ITERATIONS_DEF)
    ) u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .request    (request),
        .done       (done),
        .result     (result),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial clk = 1'b0;
    always #10 clk = ~clk;

    // Issue one transaction: raise start at a falling edge and hold it until
    // it is taken at a rising edge, optionally idling first. Start is left
    // high on return; the next call or the caller drops it.
    task automatic issue(input cpo_pkg::op_t op, input logic [11:0] x, input logic [11:0] y);
        while ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            @(negedge clk);
        end
        request.operation <= op;
        request.coord_x <= x;
        request.coord_y <= y;
        start <= 1'b1;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        @(negedge clk);
    endtask

    // Convex-ish polygon: diamond/triangle vertices around a center at radius r.
    task automatic load_polygon(input cpo_pkg::op_t op, input int cx, input int cy,
                                input int r, input int n);
        int k;
        int px;
        int py;
        for (k = 0; k < n; k++)
        begin
            case (k % 4)
                0: begin px = cx + r; py = cy; end
                1: begin px = cx; py = cy + r; end
                2: begin px = cx - r; py = cy; end
                default: begin px = cx; py = cy - r; end
            endcase
            issue(op, 12'(px), 12'(py));
        end
    endtask

    initial
    begin
        int phase;
        int n;
        int r;
        start = 1'b0;
        request = '0;
        rst_n = 1'b0;
        idle_pct = 0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // empty shapes, then one side empty
        issue(cpo_pkg::OP_RUN, 12'h000, 12'h000);
        issue(cpo_pkg::OP_APPEND_A, 12'h7ff, 12'h800);
        issue(cpo_pkg::OP_RUN, 12'h000, 12'h000);
        // extremes: opposite corners, far apart, then overlapping points
        issue(cpo_pkg::OP_APPEND_B, 12'h800, 12'h7ff);
        issue(cpo_pkg::OP_RUN, 12'h000, 12'h000);
        issue(cpo_pkg::OP_CLEAR, 12'hfff, 12'hfff);
        issue(cpo_pkg::OP_APPEND_A, 12'h000, 12'h000);
        issue(cpo_pkg::OP_APPEND_B, 12'h000, 12'h000);
        issue(cpo_pkg::OP_RUN, 12'h000, 12'h000);
        issue(cpo_pkg::OP_CLEAR, 12'h000, 12'h000);
        load_polygon(cpo_pkg::OP_APPEND_A, 0, 0, 2047, 4);
        load_polygon(cpo_pkg::OP_APPEND_B, 0, 0, 2048, 4);
        issue(cpo_pkg::OP_RUN, 12'h555, 12'haaa);
        // overfill A so vertices are dropped
        issue(cpo_pkg::OP_CLEAR, 12'h000, 12'h000);
        load_polygon(cpo_pkg::OP_APPEND_A, 10, 10, 5, 66);
        issue(cpo_pkg::OP_APPEND_B, 12'd10, 12'd10);
        issue(cpo_pkg::OP_RUN, 12'h000, 12'h000);

        for (phase = 0; phase < 4; phase++)
        begin
            idle_pct = (phase == 1) ? 81 : (phase == 3) ? 29 : 0;
            repeat (25)
            begin
                issue(cpo_pkg::OP_CLEAR, 12'($urandom), 12'($urandom));
                r = $urandom_range(400, 1);
                n = $urandom_range(3, 1);
                load_polygon(cpo_pkg::OP_APPEND_A, $signed($urandom_range(1000)) - 500,
                             $signed($urandom_range(1000)) - 500, r, n);
                load_polygon(cpo_pkg::OP_APPEND_B, $signed($urandom_range(1000)) - 500,
                             $signed($urandom_range(1000)) - 500,
                             $urandom_range(400, 1), $urandom_range(4, 1));
                // some fully random vertices as noise
                if ($urandom_range(3) == 0)
                    issue(($urandom_range(1) != 0) ? cpo_pkg::OP_APPEND_A
                                                   : cpo_pkg::OP_APPEND_B,
                          12'($urandom), 12'($urandom));
                issue(cpo_pkg::OP_RUN, 12'($urandom), 12'($urandom));
            end
        end
        start <= 1'b0;

        while (pending != 0 || busy)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    initial
    begin
        #50ms;
        $display("Regression FAIL");
        $finish;
    end
endmodule

### files.f
sv/cpo_pkg.sv
sv/cpo_ram.sv
sv/cpo_dp.sv
sv/cpo_ctrl.sv
sv/convex_polygon_overlap_test_top.sv
tb/cpo_checker.sv
tb/tb.sv
